>>> rtl/brpid_pkg.sv
// Shared types, widths and constants for the byte-rate PID controller.
`timescale 1ns / 1ps

package brpid_pkg;

  // Fixed-point format: signed 64-bit with FRAC_BITS fraction bits
  localparam int FRAC_BITS = 16;
  localparam int FX_W      = 64;

  // Field and register widths
  localparam int SENT_W    = 32;
  localparam int EL_W      = 24;
  localparam int TGT_W     = 37;
  localparam int SP_W      = 20;
  localparam int BUD_W     = 30;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = TGT_W;

  // Shared multiply / divide unit
  localparam int MUL_W  = 32;               // multiplier operand width
  localparam int PROD_W = FX_W + MUL_W;     // full product width
  localparam int DIV_W  = 35;               // divisor width (1600 * elapsed fits)
  localparam int Q_W    = FX_W;             // quotient bits produced per divide
  localparam int CNT_W  = $clog2(Q_W);

  // Numeric constants
  localparam int unsigned MICRO      = 1000000;
  localparam int unsigned BUDGET_MAX = 1000000000;
  localparam int unsigned TGT_RESET  = 40000000;
  localparam int unsigned SP_RESET   = 10000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEND_PERIOD = CFG_IDX_W'(1);

  // Request payloads
  typedef struct packed {
    logic [SENT_W-1:0] sent_bytes;
    logic [EL_W-1:0]   elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [BUD_W-1:0] budget_bytes;
    logic             hit_upper;
    logic             hit_lower;
  } out_item_t;

  // Which product-quotient the shared unit is working on
  typedef enum logic [2:0] {
    OP_MEAS,
    OP_BERR,
    OP_PROP,
    OP_INTEG,
    OP_DERIV
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    op_t  op;
    logic load_in;
    logic opnd;
    logic take_abs;
    logic mul_lo;
    logic mul_hi;
    logic psum;
    logic div_init;
    logic div_step;
    logic result;
    logic store;
    logic sum;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_sat;
  } sts_t;

endpackage

>>> rtl/brpid_ctrl.sv
// Sequencer for the PID update: walks the five product-quotients and the final sum.
`timescale 1ns / 1ps

module brpid_ctrl
  import brpid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPND,
    S_ABS,
    S_MUL_LO,
    S_MUL_HI,
    S_PSUM,
    S_DIV_INIT,
    S_DIV_STEP,
    S_RESULT,
    S_STORE,
    S_SUM,
    S_CLAMP
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.op        = op_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          op_nxt      = OP_MEAS;
          state_nxt   = S_OPND;
        end
      end
      S_OPND: begin
        cmd.opnd  = 1'b1;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        cmd.take_abs = 1'b1;
        state_nxt    = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_PSUM;
      end
      S_PSUM: begin
        cmd.psum  = 1'b1;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        // quotient already past 64 bits: skip the iterations
        state_nxt    = sts.div_sat ? S_RESULT : S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd.result = 1'b1;
        state_nxt  = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_OPND;
        unique case (op_r)
          OP_MEAS:  op_nxt = OP_BERR;
          OP_BERR:  op_nxt = OP_PROP;
          OP_PROP:  op_nxt = OP_INTEG;
          OP_INTEG: op_nxt = OP_DERIV;
          OP_DERIV: state_nxt = S_SUM;
          default:  state_nxt = S_SUM;
        endcase
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_MEAS;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.opnd, cmd.take_abs, cmd.mul_lo, cmd.mul_hi, cmd.psum,
              cmd.div_init, cmd.div_step, cmd.result, cmd.store, cmd.sum, cmd.load_out}))
    else $error("more than one datapath command in a cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new request taken while the previous one is in work");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> rtl/brpid_dp.sv
// Datapath: configuration, controller state, shared multiplier and bit-serial divider.
`timescale 1ns / 1ps

module brpid_dp
  import brpid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  in_item_t             in_data,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam logic signed [FX_W-1:0] S64_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic signed [FX_W-1:0] S64_MIN = {1'b1, {(FX_W-1){1'b0}}};
  localparam logic [FX_W-1:0] BUDGET_MAX_FX  = FX_W'(BUDGET_MAX) << FRAC_BITS;

  function automatic logic signed [FX_W-1:0] sat_add(input logic signed [FX_W-1:0] a,
                                                     input logic signed [FX_W-1:0] b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} + {b[FX_W-1], b};
    if (s[FX_W] != s[FX_W-1]) return s[FX_W] ? S64_MIN : S64_MAX;
    return s[FX_W-1:0];
  endfunction

  function automatic logic signed [FX_W-1:0] sat_sub(input logic signed [FX_W-1:0] a,
                                                     input logic signed [FX_W-1:0] b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} - {b[FX_W-1], b};
    if (s[FX_W] != s[FX_W-1]) return s[FX_W] ? S64_MIN : S64_MAX;
    return s[FX_W-1:0];
  endfunction

  // Configuration and controller state
  logic [TGT_W-1:0]        tgt_r;
  logic [SP_W-1:0]         sp_r;
  logic signed [FX_W-1:0]  integ_r;
  logic signed [FX_W-1:0]  prev_r;

  // Working registers
  logic [SENT_W-1:0]       sent_r;
  logic [EL_W-1:0]         el_r;
  logic signed [FX_W-1:0]  meas_r, rerr_r, berr_r, p_r, d_r, s1_r, res_r, a_r;
  logic [FX_W-1:0]         mag_r;
  logic                    neg_r;
  logic [MUL_W-1:0]        b_r;
  logic [DIV_W-1:0]        c_r;
  logic [FX_W-1:0]         pp_lo_r, pp_hi_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DIV_W-1:0]        rem_r;
  logic [Q_W-1:0]          quo_r;
  logic                    sat_r;
  out_item_t               out_r, out_nxt;

  // Combinational helpers
  logic signed [FX_W-1:0]  tgt_fx;
  logic signed [FX_W-1:0]  opnd_a;
  logic [MUL_W-1:0]        opnd_b;
  logic [DIV_W-1:0]        opnd_c;
  logic [MUL_W-1:0]        mul_a;
  logic [2*MUL_W-1:0]      mul_res;
  logic [PROD_W-Q_W-1:0]   n_high;
  logic [DIV_W:0]          div_t, div_diff;
  logic                    div_ge;
  logic [FX_W-1:0]         lim, tot;
  logic signed [FX_W-1:0]  sum_fin;

  assign tgt_fx = signed'(FX_W'(tgt_r) << FRAC_BITS);

  // Operand select for each product-quotient a * b / c
  always_comb begin
    case (cmd.op)
      OP_MEAS: begin
        opnd_a = signed'(FX_W'(sent_r) << FRAC_BITS);
        opnd_b = MUL_W'(MICRO);
        opnd_c = DIV_W'(el_r);
      end
      OP_BERR: begin
        opnd_a = tgt_fx - meas_r;
        opnd_b = MUL_W'(sp_r);
        opnd_c = DIV_W'(MICRO);
      end
      OP_PROP: begin
        opnd_a = berr_r;
        opnd_b = MUL_W'(3);
        opnd_c = DIV_W'(10);
      end
      OP_INTEG: begin
        opnd_a = berr_r;
        opnd_b = (MUL_W'(el_r) << 3) + (MUL_W'(el_r) << 2);   // 12 * elapsed
        opnd_c = DIV_W'(MICRO);
      end
      OP_DERIV: begin
        opnd_a = sat_sub(rerr_r, prev_r);
        opnd_b = (MUL_W'(sp_r) << 1) + MUL_W'(sp_r);           // 3 * period
        opnd_c = (DIV_W'(el_r) << 10) + (DIV_W'(el_r) << 9)
               + (DIV_W'(el_r) << 6);                          // 1600 * elapsed
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
        opnd_c = DIV_W'(1);
      end
    endcase
  end

  // Shared 32x32 multiplier, one half of the magnitude per cycle
  assign mul_a   = cmd.mul_hi ? mag_r[FX_W-1:MUL_W] : mag_r[MUL_W-1:0];
  assign mul_res = (2*MUL_W)'(mul_a) * (2*MUL_W)'(b_r);

  // Divider: quotient fits 64 bits only if the top of the product is below c
  assign n_high      = prod_r[PROD_W-1:Q_W];
  assign sts.div_sat = (DIV_W'(n_high) >= c_r);
  assign div_t       = {rem_r, quo_r[Q_W-1]};
  assign div_diff    = div_t - {1'b0, c_r};
  assign div_ge      = (div_t >= {1'b0, c_r});

  // Clamp magnitude to the signed limit, then restore the sign
  assign lim = neg_r ? {1'b1, {(FX_W-1){1'b0}}} : {1'b0, {(FX_W-1){1'b1}}};
  assign tot = (sat_r || (quo_r > lim)) ? lim : quo_r;

  // Final sum and budget clamp
  assign sum_fin = sat_add(s1_r, d_r);
  always_comb begin
    out_nxt = '0;
    if (sum_fin[FX_W-1]) begin
      out_nxt.hit_lower = 1'b1;
    end else if (unsigned'(sum_fin) > BUDGET_MAX_FX) begin
      out_nxt.budget_bytes = BUD_W'(BUDGET_MAX);
      out_nxt.hit_upper    = 1'b1;
    end else begin
      out_nxt.budget_bytes = sum_fin[FRAC_BITS +: BUD_W];
    end
  end

  // Registers with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r   <= TGT_W'(TGT_RESET);
      sp_r    <= SP_W'(SP_RESET);
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx)
          REG_TARGET_RATE: tgt_r <= cfg_data;
          REG_SEND_PERIOD: sp_r  <= cfg_data[SP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.store && (cmd.op == OP_INTEG)) begin
        integ_r <= sat_add(integ_r, res_r);
      end
      if (cmd.store && (cmd.op == OP_DERIV)) begin
        prev_r <= rerr_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sent_r <= in_data.sent_bytes;
      el_r   <= (in_data.elapsed_us == '0) ? EL_W'(1) : in_data.elapsed_us;
    end
    if (cmd.opnd) begin
      a_r <= opnd_a;
      b_r <= opnd_b;
      c_r <= opnd_c;
      if (cmd.op == OP_BERR) begin
        rerr_r <= meas_r - tgt_fx;
      end
    end
    if (cmd.take_abs) begin
      neg_r <= a_r[FX_W-1];
      mag_r <= a_r[FX_W-1] ? unsigned'(-a_r) : unsigned'(a_r);
    end
    if (cmd.mul_lo) begin
      pp_lo_r <= mul_res;
    end
    if (cmd.mul_hi) begin
      pp_hi_r <= mul_res;
    end
    if (cmd.psum) begin
      prod_r <= PROD_W'(pp_lo_r) + {pp_hi_r, {MUL_W{1'b0}}};
    end
    if (cmd.div_init) begin
      rem_r <= DIV_W'(n_high);
      quo_r <= prod_r[Q_W-1:0];
      sat_r <= sts.div_sat;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? div_diff[DIV_W-1:0] : div_t[DIV_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], div_ge};
    end
    if (cmd.result) begin
      res_r <= neg_r ? signed'(-tot) : signed'(tot);
    end
    if (cmd.store) begin
      case (cmd.op)
        OP_MEAS:  meas_r <= res_r;
        OP_BERR:  berr_r <= res_r;
        OP_PROP:  p_r    <= res_r;
        OP_DERIV: d_r    <= res_r;
        default: ;
      endcase
    end
    if (cmd.sum) begin
      s1_r <= sat_add(p_r, integ_r);
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/byte_rate_pid_controller.sv
// Each of the five product-quotients runs operand select, absolute value, low and high
//   multiply, partial sum, divide init, divide steps (skipped when its quotient saturates),
//   result and store; sum and budget clamp follow. A new request is taken only once the
//   result is loaded. The shared divider gives one quotient bit per cycle, 64 per quotient.
// Reset (synchronous, active low): target rate 40000000, send period 10000 us,
//   integral and previous rate error zero, no result pending.
`timescale 1ns / 1ps

module byte_rate_pid_controller
  import brpid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  brpid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brpid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the byte-rate PID controller: bit-true budget prediction.
`timescale 1ns / 1ps

module tb;
  import brpid_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int TAIL_CYCLES = 400;
  localparam longint unsigned POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned NEG_MAG = 64'h8000_0000_0000_0000;
  localparam logic [EL_W-1:0]   EL_MAX   = '1;
  localparam logic [SENT_W-1:0] SENT_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = '1;
  // budget ceiling in fixed point
  localparam longint UPPER_FX = longint'(BUDGET_MAX) <<< FRAC_BITS;
  // integral level, in bytes, past which stimulus steers it back toward zero
  localparam longint DRAIN_LEVEL = longint'(200000000) <<< FRAC_BITS;

  typedef logic signed [63:0] fx_t;

  // Budget predictor plus the queue of budgets still owed by the block
  class budget_scoreboard;
    logic [TGT_W-1:0] target_rate;
    logic [SP_W-1:0]  send_period;
    fx_t              last_rate_err;
    fx_t              integral;
    logic [BUD_W-1:0] last_budget;
    out_item_t        budget_q[$];
    int               errors;

    function new();
      target_rate   = TGT_W'(TGT_RESET);
      send_period   = SP_W'(SP_RESET);
      last_rate_err = '0;
      integral      = '0;
      last_budget   = '0;
      errors        = 0;
    endfunction

    function fx_t sat(logic signed [65:0] v);
      if (v > $signed({2'b00, POS_MAX})) return fx_t'(POS_MAX);
      if (v < $signed({2'b11, NEG_MAG})) return fx_t'(NEG_MAG);
      return v[63:0];
    endfunction

    function fx_t add_sat(fx_t a, fx_t b);
      logic signed [65:0] w;
      w = a;
      w = w + b;
      return sat(w);
    endfunction

    function fx_t sub_sat(fx_t a, fx_t b);
      logic signed [65:0] w;
      w = a;
      w = w - b;
      return sat(w);
    endfunction

    // a * b / c, exact product, truncated toward zero, then saturated
    function fx_t scale(fx_t a, logic [63:0] b, logic [63:0] c);
      logic [63:0]  mag;
      logic [63:0]  lim;
      logic [127:0] q;
      mag = a[63] ? -a : a;
      lim = a[63] ? NEG_MAG : POS_MAX;
      q = {64'd0, mag} * {64'd0, b} / {64'd0, c};
      if (q > {64'd0, lim}) q = {64'd0, lim};
      return a[63] ? -fx_t'(q[63:0]) : fx_t'(q[63:0]);
    endfunction

    // One control update from the given state: new rate error, new integral, raw sum
    function void evaluate(input in_item_t req, input fx_t prev_err, input fx_t integ_in,
                           output fx_t rate_err, output fx_t integ_out, output fx_t pid_sum);
      logic [63:0] el, bytes_us, whole, rem, frac, tgt_fx;
      fx_t         meas, byte_err, prop, deriv;
      el       = (req.elapsed_us == '0) ? 64'd1 : 64'(req.elapsed_us);
      bytes_us = 64'(req.sent_bytes) * 64'(MICRO);
      whole    = bytes_us / el;
      rem      = bytes_us % el;
      frac     = (rem << FRAC_BITS) / el;
      meas     = (whole > (POS_MAX >> FRAC_BITS)) ? fx_t'(POS_MAX)
                                                  : fx_t'((whole << FRAC_BITS) + frac);
      tgt_fx   = 64'(target_rate) << FRAC_BITS;
      rate_err = sub_sat(meas, fx_t'(tgt_fx));
      byte_err = scale(sub_sat(fx_t'(tgt_fx), meas), 64'(send_period), 64'(MICRO));
      prop     = scale(byte_err, 64'd3, 64'd10);
      integ_out = add_sat(integ_in, scale(byte_err, 64'd12 * el, 64'(MICRO)));
      deriv    = scale(sub_sat(rate_err, prev_err), 64'd3 * 64'(send_period), 64'd1600 * el);
      pid_sum  = add_sat(add_sat(prop, integ_out), deriv);
    endfunction

    function out_item_t clamp_budget(fx_t pid_sum);
      out_item_t res;
      res = '0;
      if (pid_sum < 0) begin
        res.hit_lower = 1'b1;
      end else if ($unsigned(pid_sum) > $unsigned(UPPER_FX)) begin
        res.budget_bytes = BUD_W'(BUDGET_MAX);
        res.hit_upper    = 1'b1;
      end else begin
        res.budget_bytes = BUD_W'(pid_sum >>> FRAC_BITS);
      end
      return res;
    endfunction

    function fx_t preview_sum(logic [SENT_W-1:0] sent, logic [EL_W-1:0] el);
      in_item_t req;
      fx_t      rate_err, integ, pid_sum;
      req.sent_bytes = sent;
      req.elapsed_us = el;
      evaluate(req, last_rate_err, integral, rate_err, integ, pid_sum);
      return pid_sum;
    endfunction

    // Bisects sent_bytes for neighbors whose sums fall on opposite sides of thr
    function logic [SENT_W-1:0] find_edge(logic [EL_W-1:0] el, fx_t thr);
      logic [SENT_W-1:0] lo, hi, mid;
      logic              lo_above;
      lo = '0;
      hi = '1;
      lo_above = preview_sum(lo, el) > thr;
      if ((preview_sum(hi, el) > thr) == lo_above) return lo;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if ((preview_sum(mid, el) > thr) == lo_above) lo = mid;
        else hi = mid;
      end
      return lo;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == REG_TARGET_RATE) target_rate = val[TGT_W-1:0];
      else if (idx == REG_SEND_PERIOD) send_period = val[SP_W-1:0];
    endfunction

    function void note_request(in_item_t req);
      fx_t       rate_err, integ, pid_sum;
      out_item_t res;
      evaluate(req, last_rate_err, integral, rate_err, integ, pid_sum);
      last_rate_err = rate_err;
      integral      = integ;
      res           = clamp_budget(pid_sum);
      last_budget   = res.budget_bytes;
      budget_q.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (budget_q.size() == 0) begin
        $display("%0t: unexpected result, budget %0d upper %0b lower %0b", $time,
                 got.budget_bytes, got.hit_upper, got.hit_lower);
        errors++;
        return;
      end
      want = budget_q.pop_front();
      compare_field("budget_bytes", want.budget_bytes, got.budget_bytes);
      compare_field("hit_upper", want.hit_upper, got.hit_upper);
      compare_field("hit_lower", want.hit_lower, got.hit_lower);
    endfunction

    function int pending();
      return budget_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;

  int send_idle_pct;
  int stall_pct;
  int hold_len;
  int cycles;
  budget_scoreboard sb;

  byte_rate_pid_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_len != 0) begin
      out_ready <= 1'b0;
      hold_len  <= hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic in_item_t make_req(logic [SENT_W-1:0] sent, logic [EL_W-1:0] el);
    in_item_t req;
    req.sent_bytes = sent;
    req.elapsed_us = el;
    return req;
  endfunction

  // Mostly closed-loop traffic that follows the predicted budget, plus noise and corners
  function automatic in_item_t next_request();
    logic [63:0] base_el, el, sent;
    int          pick;
    pick    = $urandom_range(0, 99);
    base_el = (sb.send_period == '0) ? 64'd10000 : 64'(sb.send_period);
    if (pick < 10) begin
      return make_req($urandom, EL_W'($urandom));
    end else if (pick < 20) begin
      case ($urandom_range(0, 2))
        0:       sent = '0;
        1:       sent = 64'(SENT_MAX);
        default: sent = 64'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       el = '0;
        1:       el = 64'd1;
        2:       el = 64'(EL_MAX);
        default: el = 64'($urandom_range(2, 100));
      endcase
      return make_req(sent[SENT_W-1:0], el[EL_W-1:0]);
    end else if (sb.integral > DRAIN_LEVEL) begin
      return make_req(SENT_MAX, EL_MAX);
    end else if (sb.integral < -DRAIN_LEVEL) begin
      return make_req('0, EL_MAX);
    end
    el = base_el * $urandom_range(50, 150) / 100;
    if (el == 0) el = 64'd1;
    if (el > 64'(EL_MAX)) el = 64'(EL_MAX);
    sent = 64'(sb.last_budget) * el / base_el * $urandom_range(75, 125) / 100
           + $urandom_range(0, 1000);
    if (sent > 64'(SENT_MAX)) sent = 64'(SENT_MAX);
    return make_req(sent[SENT_W-1:0], el[EL_W-1:0]);
  endfunction

  // Offer one request, idling first at random; valid stays up between back-to-back requests
  task automatic send_req(input in_item_t req);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Settings change only once the block has nothing in flight
  task automatic configure(input logic [CFG_DAT_W-1:0] rate, input logic [CFG_DAT_W-1:0] period,
                           input bit with_unused);
    wait_drained();
    if (with_unused) begin
      write_reg(REG_UNUSED, CFG_DAT_W'({$urandom, $urandom}));
      write_reg(REG_TOP_IDX, '1);
    end
    write_reg(REG_TARGET_RATE, rate);
    write_reg(REG_SEND_PERIOD, period);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) send_req(next_request());
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 0;
    cycles        = 0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes at reset settings
    send_req(make_req('0, '0));                // zero elapsed time counts as one us
    send_req(make_req(SENT_MAX, EL_W'(1)));    // measured rate saturates
    send_req(make_req(SENT_MAX, EL_MAX));
    send_req(make_req('0, EL_MAX));
    send_req(make_req(SENT_W'(400000), EL_W'(10000)));   // right on target
    send_req(make_req('0, EL_W'(10000)));
    send_req(make_req(SENT_W'(1234567), EL_W'(10000000)));
    send_req(make_req($urandom, EL_W'(1)));
    // sum straddling zero: lower clamp edge
    send_req(make_req(sb.find_edge(EL_W'(10000), -1), EL_W'(10000)));
    send_req(make_req(sb.find_edge(EL_W'(10000), -1) + 1'b1, EL_W'(10000)));

    // Random phases with different idling
    run_phase(450, 0, 0);
    configure(CFG_DAT_W'(1000000), CFG_DAT_W'(100000), 1'b0);
    run_phase(350, 60, 0);
    configure(CFG_DAT_W'(100000000), CFG_DAT_W'(1000), 1'b0);
    run_phase(350, 0, 60);
    configure(CFG_DAT_W'(TGT_RESET), CFG_DAT_W'(SP_RESET), 1'b0);
    run_phase(100, 27, 27);
    // receiver holds off for a long stretch while requests keep coming
    hold_len <= 3000;
    run_phase(100, 27, 27);
    // sender pauses until every budget is back
    wait_drained();
    run_phase(150, 27, 27);

    // Zero target and period, plus writes to indexes with no register
    configure('0, '0, 1'b1);
    run_phase(30, 27, 27);
    // High target: both clamp edges
    configure(37'd100000000000, CFG_DAT_W'(100000), 1'b0);
    send_req(make_req(sb.find_edge(EL_W'(1000), UPPER_FX), EL_W'(1000)));
    send_req(make_req(sb.find_edge(EL_W'(1000), -1), EL_W'(1000)));
    run_phase(30, 27, 27);
    // Full-width target; period write carries junk above its 20 bits (period 1)
    configure('1, 37'h1F_FFF0_0001, 1'b0);
    run_phase(30, 27, 27);
    configure(CFG_DAT_W'(1000000), CFG_DAT_W'(20'hFFFFF), 1'b0);
    run_phase(30, 27, 27);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
